/* src/plc_pkg.sv */
// Shared types, widths and codes for the piecewise-linear calibration block.
// Used by the index, interpolation and top modules under src and by the testbench; depends on nothing else.
package plc_pkg;

	// Value and table geometry.
	localparam int VALUE_BITS    = 24;
	localparam int FWD_DEPTH     = 1024;
	localparam int INV_POINTS    = 1024;
	localparam int FWD_AW        = $clog2(FWD_DEPTH);
	localparam int INV_AW        = $clog2(INV_POINTS);

	// Scaling arithmetic.
	localparam int SCALE_BITS    = 32;
	localparam int FRAC_BITS     = 16;
	localparam int POS_BITS      = VALUE_BITS + SCALE_BITS;
	localparam int IDX_BITS      = POS_BITS - FRAC_BITS;
	localparam int PROD_BITS     = VALUE_BITS + FRAC_BITS + 2;
	localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);

	// Field widths of the ports.
	localparam int KIND_BITS     = 2;
	localparam int ENTRY_BITS    = 10;
	localparam int POINTS_BITS   = 11;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [SCALE_BITS-1:0]        scale_t;

	// Request kinds.
	typedef enum logic [KIND_BITS-1:0] {
		KIND_FWD    = 2'd0,
		KIND_INV    = 2'd1,
		KIND_WR_FWD = 2'd2,
		KIND_WR_INV = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ENABLE     = 3'd0,
		REG_X_LOW      = 3'd1,
		REG_X_HIGH     = 3'd2,
		REG_X_SCALE    = 3'd3,
		REG_FWD_POINTS = 3'd4,
		REG_Y_LOW      = 3'd5,
		REG_Y_HIGH     = 3'd6,
		REG_Y_SCALE    = 3'd7
	} cfg_reg_t;

	// Configuration as seen by the datapath, with derived values.
	typedef struct packed {
		logic              enable;
		value_t            x_low;
		value_t            x_high;
		scale_t            x_scale;
		logic [FWD_AW-1:0] fwd_nm1;
		value_t            y_low;
		value_t            y_high;
		scale_t            y_scale;
		logic              slope_pos;
	} cfg_t;

	// Table memory accesses issued by the index stage.
	typedef struct packed {
		logic              we_fwd;
		logic [FWD_AW-1:0] waddr_fwd;
		logic [FWD_AW-1:0] ra_fwd;
		logic [FWD_AW-1:0] rb_fwd;
		logic              we_inv;
		logic [INV_AW-1:0] waddr_inv;
		logic [INV_AW-1:0] ra_inv;
		logic [INV_AW-1:0] rb_inv;
		value_t            wdata;
	} tbl_req_t;

	// Per-conversion control that travels alongside the table read.
	typedef struct packed {
		logic                 valid;
		logic                 is_fwd;
		logic                 below;
		logic                 above;
		logic                 a_only;
		logic                 end_clip;
		logic [FRAC_BITS-1:0] frac;
	} ctl_t;

endpackage

/* src/plc_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Stand-alone; used for both calibration tables.
module plc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and both reads happen on the same edge; reads return old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* src/plc_index.sv */
// Front stages: range check, grid offset, Q16.16 scaling and table addressing.
// Depends on plc_pkg; drives the table memories and the interpolation stages.
module plc_index (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [plc_pkg::KIND_BITS-1:0]     kind,
	input  plc_pkg::value_t                   operand,
	input  logic [plc_pkg::ENTRY_BITS-1:0]    entry_index,
	input  plc_pkg::cfg_t                     cfg,
	output plc_pkg::tbl_req_t                 tbl,
	output plc_pkg::ctl_t                     ctl
);
	import plc_pkg::*;

	kind_t                   kind_in;
	logic                    is_fwd_in;
	value_t                  low;
	value_t                  high;
	logic signed [VALUE_BITS:0] diff;

	logic                    conv_s1;
	logic                    wr_s1;
	logic                    wr_fwd_s1;
	logic                    is_fwd_s1;
	logic                    below_s1;
	logic                    above_s1;
	logic [VALUE_BITS-1:0]   ofs_s1;
	value_t                  data_s1;
	logic [ENTRY_BITS-1:0]   entry_s1;
	scale_t                  scale_s1;
	logic [POS_BITS-1:0]     prod_s1;

	logic                    conv_s2;
	logic                    wr_s2;
	logic                    wr_fwd_s2;
	logic                    is_fwd_s2;
	logic                    below_s2;
	logic                    above_s2;
	logic [POS_BITS-1:0]     pos_s2;
	value_t                  data_s2;
	logic [ENTRY_BITS-1:0]   entry_s2;

	logic [IDX_BITS-1:0]     idx;
	logic [FRAC_BITS-1:0]    frac;
	logic [IDX_BITS-1:0]     nm1;
	logic                    at_end;
	logic                    beyond;

	// Select the grid of the request and measure the offset from its start.
	always_comb begin
		kind_in   = kind_t'(kind);
		is_fwd_in = (kind_in == KIND_FWD);
		low       = is_fwd_in ? cfg.x_low : cfg.y_low;
		high      = is_fwd_in ? cfg.x_high : cfg.y_high;
		diff      = (VALUE_BITS+1)'(operand) - (VALUE_BITS+1)'(low);
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			conv_s1 <= req_valid && (kind_in == KIND_FWD || kind_in == KIND_INV);
			wr_s1   <= req_valid && (kind_in == KIND_WR_FWD || kind_in == KIND_WR_INV);
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		wr_fwd_s1 <= (kind_in == KIND_WR_FWD);
		is_fwd_s1 <= is_fwd_in;
		below_s1  <= (operand < low);
		above_s1  <= (operand > high);
		ofs_s1    <= diff[VALUE_BITS-1:0];
		data_s1   <= operand;
		entry_s1  <= entry_index;
	end

	// Scale the offset into grid steps with a Q16.16 factor.
	assign scale_s1 = is_fwd_s1 ? cfg.x_scale : cfg.y_scale;
	assign prod_s1  = POS_BITS'(ofs_s1) * POS_BITS'(scale_s1);

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_s2 <= 1'b0;
			wr_s2   <= 1'b0;
		end else begin
			conv_s2 <= conv_s1;
			wr_s2   <= wr_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		wr_fwd_s2 <= wr_fwd_s1;
		is_fwd_s2 <= is_fwd_s1;
		below_s2  <= below_s1;
		above_s2  <= above_s1;
		pos_s2    <= prod_s1;
		data_s2   <= data_s1;
		entry_s2  <= entry_s1;
	end

	// Split the position into index and fraction and detect the grid end.
	always_comb begin
		idx    = pos_s2[POS_BITS-1:FRAC_BITS];
		frac   = pos_s2[FRAC_BITS-1:0];
		nm1    = is_fwd_s2 ? IDX_BITS'(cfg.fwd_nm1) : IDX_BITS'(INV_POINTS - 1);
		at_end = (idx >= nm1);
		beyond = (idx > nm1) || (frac != '0);
	end

	// Table accesses. Writes are issued in the same stage as reads, so every
	// conversion sees exactly the writes requested before it.
	always_comb begin
		tbl.we_fwd    = wr_s2 && wr_fwd_s2 && (32'(entry_s2) < FWD_DEPTH);
		tbl.waddr_fwd = FWD_AW'(entry_s2);
		tbl.we_inv    = wr_s2 && !wr_fwd_s2 && (32'(entry_s2) < INV_POINTS);
		tbl.waddr_inv = INV_AW'(entry_s2);
		tbl.wdata     = data_s2;
		if (below_s2) begin
			tbl.ra_fwd = '0;
		end else if (above_s2 || at_end) begin
			tbl.ra_fwd = cfg.fwd_nm1;
		end else begin
			tbl.ra_fwd = idx[FWD_AW-1:0];
		end
		tbl.rb_fwd = idx[FWD_AW-1:0] + FWD_AW'(1);
		tbl.ra_inv = at_end ? INV_AW'(INV_POINTS - 1) : idx[INV_AW-1:0];
		tbl.rb_inv = idx[INV_AW-1:0] + INV_AW'(1);
	end

	// Control for the interpolation stages.
	always_comb begin
		ctl.valid    = conv_s2;
		ctl.is_fwd   = is_fwd_s2;
		ctl.below    = below_s2;
		ctl.above    = above_s2;
		ctl.a_only   = is_fwd_s2 ? (below_s2 || above_s2 || at_end) : at_end;
		ctl.end_clip = at_end && beyond;
		ctl.frac     = frac;
	end

endmodule

/* src/plc_interp.sv */
// Back stages: linear interpolation with rounding, inverse result limiting
// and the result register. Depends on plc_pkg and the table read data.
module plc_interp (
	input  logic            clk,
	input  logic            arst_n,
	input  plc_pkg::ctl_t   ctl,
	input  plc_pkg::value_t fwd_a,
	input  plc_pkg::value_t fwd_b,
	input  plc_pkg::value_t inv_a,
	input  plc_pkg::value_t inv_b,
	input  plc_pkg::cfg_t   cfg,
	output logic            done,
	output plc_pkg::value_t converted,
	output logic            clamped
);
	import plc_pkg::*;

	logic                        valid_s3;
	ctl_t                        ctl_s3;
	value_t                      a_s3;
	value_t                      b_s3;
	logic signed [VALUE_BITS:0]  diff_s3;
	logic signed [PROD_BITS-1:0] prod_s3;

	logic                        valid_s4;
	ctl_t                        ctl_s4;
	value_t                      a_s4;
	logic signed [PROD_BITS-1:0] prod_s4;
	logic signed [PROD_BITS-1:0] rnd;
	logic signed [PROD_BITS-1:0] step;
	logic signed [PROD_BITS-1:0] sum;
	value_t                      r_s4;

	logic                        valid_s5;
	ctl_t                        ctl_s5;
	value_t                      r_s5;
	value_t                      lim1;
	value_t                      lim2;
	value_t                      res;
	logic                        clip;

	logic                        done_q;
	value_t                      converted_q;
	logic                        clamped_q;

	// Stage 3 holds the control that goes with the registered table data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl;
	end

	// Slope between neighboring entries times the fraction.
	always_comb begin
		a_s3    = ctl_s3.is_fwd ? fwd_a : inv_a;
		b_s3    = ctl_s3.is_fwd ? fwd_b : inv_b;
		diff_s3 = (VALUE_BITS+1)'(b_s3) - (VALUE_BITS+1)'(a_s3);
		prod_s3 = PROD_BITS'(diff_s3) * PROD_BITS'($signed({1'b0, ctl_s3.frac}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4  <= ctl_s3;
		a_s4    <= a_s3;
		prod_s4 <= prod_s3;
	end

	// Round to nearest with ties upward, then add the lower entry.
	always_comb begin
		rnd  = prod_s4 + PROD_BITS'(ROUND_HALF);
		step = rnd >>> FRAC_BITS;
		sum  = PROD_BITS'(a_s4) + step;
		r_s4 = ctl_s4.a_only ? a_s4 : value_t'(sum[VALUE_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s5 <= ctl_s4;
		r_s5   <= r_s4;
	end

	// Limit an inverse result to the x range in the order set by the slope,
	// and pick the final value for each kind of conversion.
	always_comb begin
		if (cfg.slope_pos) begin
			lim1 = (r_s5 > cfg.x_high) ? cfg.x_high : r_s5;
			lim2 = (lim1 < cfg.x_low) ? cfg.x_low : lim1;
		end else begin
			lim1 = (r_s5 < cfg.x_high) ? cfg.x_high : r_s5;
			lim2 = (lim1 > cfg.x_low) ? cfg.x_low : lim1;
		end
		if (!cfg.enable) begin
			res  = '0;
			clip = 1'b0;
		end else if (ctl_s5.is_fwd) begin
			res  = r_s5;
			clip = ctl_s5.below || ctl_s5.above || ctl_s5.end_clip;
		end else if (ctl_s5.below) begin
			res  = cfg.x_low;
			clip = 1'b1;
		end else if (ctl_s5.above) begin
			res  = cfg.x_high;
			clip = 1'b1;
		end else begin
			res  = lim2;
			clip = ctl_s5.end_clip || (lim2 != r_s5);
		end
	end

	// Result register; the strobe lasts one cycle per conversion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		converted_q <= res;
		clamped_q   <= clip;
	end

	assign done      = done_q;
	assign converted = converted_q;
	assign clamped   = clamped_q;

endmodule

/* src/piecewise_linear_calibration_top.sv */
// Top level: configuration registers, the two table memories and the pipeline.
// A conversion request passes the stage 1 and stage 2 registers, the table read
// registers, stages 4 and 5 and the result register, where done marks its result.
// Throughput: one request per cycle, set by the two read ports of each table memory;
// writes give no result. busy stays low and the receiver cannot stall. Reset loads
// the register reset values; the table contents stay undefined until written.
module piecewise_linear_calibration_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [plc_pkg::KIND_BITS-1:0]      kind,
	input  plc_pkg::value_t                    operand,
	input  logic [plc_pkg::ENTRY_BITS-1:0]     entry_index,
	output logic                               done,
	output plc_pkg::value_t                    converted,
	output logic                               clamped,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [plc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [plc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import plc_pkg::*;

	logic                    enable_q;
	value_t                  x_low_q;
	value_t                  x_high_q;
	scale_t                  x_scale_q;
	logic [POINTS_BITS-1:0]  fwd_points_q;
	value_t                  y_low_q;
	value_t                  y_high_q;
	scale_t                  y_scale_q;
	logic [FWD_AW-1:0]       fwd_nm1_q;
	logic                    slope_pos_q;

	logic signed [VALUE_BITS:0] dy;
	logic signed [VALUE_BITS:0] dx;
	logic                    slope_pos_d;
	logic [FWD_AW-1:0]       fwd_nm1_d;

	cfg_t                    cfg;
	tbl_req_t                tbl;
	ctl_t                    ctl;
	value_t                  fwd_rd_a;
	value_t                  fwd_rd_b;
	value_t                  inv_rd_a;
	value_t                  inv_rd_b;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			x_low_q      <= '0;
			x_high_q     <= '0;
			x_scale_q    <= '0;
			fwd_points_q <= POINTS_BITS'(2);
			y_low_q      <= '0;
			y_high_q     <= '0;
			y_scale_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLE:     enable_q     <= cfg_data[0];
				REG_X_LOW:      x_low_q      <= cfg_data[VALUE_BITS-1:0];
				REG_X_HIGH:     x_high_q     <= cfg_data[VALUE_BITS-1:0];
				REG_X_SCALE:    x_scale_q    <= cfg_data[SCALE_BITS-1:0];
				REG_FWD_POINTS: fwd_points_q <= cfg_data[POINTS_BITS-1:0];
				REG_Y_LOW:      y_low_q      <= cfg_data[VALUE_BITS-1:0];
				REG_Y_HIGH:     y_high_q     <= cfg_data[VALUE_BITS-1:0];
				REG_Y_SCALE:    y_scale_q    <= cfg_data[SCALE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Slope direction and the saturated last forward index.
	always_comb begin
		dy          = (VALUE_BITS+1)'(y_high_q) - (VALUE_BITS+1)'(y_low_q);
		dx          = (VALUE_BITS+1)'(x_high_q) - (VALUE_BITS+1)'(x_low_q);
		slope_pos_d = (dy > 0 && dx > 0) || (dy < 0 && dx < 0);
		if (int'(fwd_points_q) < 2) begin
			fwd_nm1_d = FWD_AW'(1);
		end else if (int'(fwd_points_q) > FWD_DEPTH) begin
			fwd_nm1_d = FWD_AW'(FWD_DEPTH - 1);
		end else begin
			fwd_nm1_d = FWD_AW'(fwd_points_q - POINTS_BITS'(1));
		end
	end

	// Derived values are registered; they settle while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_nm1_q   <= FWD_AW'(1);
			slope_pos_q <= 1'b0;
		end else begin
			fwd_nm1_q   <= fwd_nm1_d;
			slope_pos_q <= slope_pos_d;
		end
	end

	always_comb begin
		cfg.enable    = enable_q;
		cfg.x_low     = x_low_q;
		cfg.x_high    = x_high_q;
		cfg.x_scale   = x_scale_q;
		cfg.fwd_nm1   = fwd_nm1_q;
		cfg.y_low     = y_low_q;
		cfg.y_high    = y_high_q;
		cfg.y_scale   = y_scale_q;
		cfg.slope_pos = slope_pos_q;
	end

	// Range check, scaling and table addressing.
	plc_index u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (start && !busy),
		.kind        (kind),
		.operand     (operand),
		.entry_index (entry_index),
		.cfg         (cfg),
		.tbl         (tbl),
		.ctl         (ctl)
	);

	// Forward table.
	plc_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (FWD_DEPTH)
	) u_fwd_ram (
		.clk     (clk),
		.we      (tbl.we_fwd),
		.waddr   (tbl.waddr_fwd),
		.wdata   (tbl.wdata),
		.raddr_a (tbl.ra_fwd),
		.raddr_b (tbl.rb_fwd),
		.rdata_a (fwd_rd_a),
		.rdata_b (fwd_rd_b)
	);

	// Inverse table.
	plc_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (INV_POINTS)
	) u_inv_ram (
		.clk     (clk),
		.we      (tbl.we_inv),
		.waddr   (tbl.waddr_inv),
		.wdata   (tbl.wdata),
		.raddr_a (tbl.ra_inv),
		.raddr_b (tbl.rb_inv),
		.rdata_a (inv_rd_a),
		.rdata_b (inv_rd_b)
	);

	// Interpolation, limiting and the result register.
	plc_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.fwd_a     (fwd_rd_a),
		.fwd_b     (fwd_rd_b),
		.inv_a     (inv_rd_a),
		.inv_b     (inv_rd_b),
		.cfg       (cfg),
		.done      (done),
		.converted (converted),
		.clamped   (clamped)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench for piecewise_linear_calibration_top.
// Depends on plc_pkg and the top module under src; it predicts each conversion
// from its own copy of the tables and registers and checks every done strobe.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plc_pkg::*;

	localparam int SETTLE_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int REPORT_LIMIT    = 10;
	localparam int PHASE_REQUESTS  = 80;
	localparam longint VALUE_MIN   = -(64'sd1 <<< (VALUE_BITS - 1));
	localparam longint VALUE_MAX   = (64'sd1 <<< (VALUE_BITS - 1)) - 1;

	typedef struct {
		kind_t                 kind;
		value_t                operand;
		logic [ENTRY_BITS-1:0] entry_index;
	} calib_req_t;

	typedef struct packed {
		value_t converted;
		logic   clamped;
	} calib_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [KIND_BITS-1:0]     kind = '0;
	value_t                   operand = '0;
	logic [ENTRY_BITS-1:0]    entry_index = '0;
	logic                     done;
	value_t                   converted;
	logic                     clamped;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// Pending requests, expected conversions and the mirrored block state.
	calib_req_t    calib_requests[$];
	calib_result_t pending_conversions[$];
	longint        fwd_model[FWD_DEPTH];
	longint        inv_model[INV_POINTS];
	bit            cal_enable;
	longint        cal_x_low, cal_x_high, cal_y_low, cal_y_high, cal_points;
	longint unsigned cal_x_scale, cal_y_scale;

	int fault_count = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;

	piecewise_linear_calibration_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.operand     (operand),
		.entry_index (entry_index),
		.done        (done),
		.converted   (converted),
		.clamped     (clamped),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Clock: 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("%0t ns: %s", $time, what);
	endtask

	// Reads two neighboring grid entries and interpolates with round half up.
	function automatic longint grid_lookup(input bit on_fwd, input longint npts,
			input longint unsigned offs, input longint unsigned scale, inout bit clip);
		longint unsigned pos, idx;
		longint frac, lo_val, hi_val;
		pos = offs * scale;
		idx = pos >> FRAC_BITS;
		frac = longint'(pos & 64'hFFFF);
		if (idx >= npts - 1) begin
			if (idx > npts - 1 || frac != 0)
				clip = 1'b1;
			return on_fwd ? fwd_model[npts - 1] : inv_model[npts - 1];
		end
		lo_val = on_fwd ? fwd_model[idx] : inv_model[idx];
		hi_val = on_fwd ? fwd_model[idx + 1] : inv_model[idx + 1];
		return lo_val + (((hi_val - lo_val) * frac + ROUND_HALF) >>> FRAC_BITS);
	endfunction

	// Predicts the result of one conversion request.
	function automatic calib_result_t convert_point(input kind_t k, input value_t operand_v);
		longint v, r, raw, n, dx, dy;
		bit clip, rising;
		calib_result_t res;
		v = operand_v;
		r = 0;
		clip = 1'b0;
		if (cal_enable && k == KIND_FWD) begin
			n = cal_points;
			if (n < 2) n = 2;
			if (n > FWD_DEPTH) n = FWD_DEPTH;
			if (v < cal_x_low) begin
				r = fwd_model[0];
				clip = 1'b1;
			end else if (v > cal_x_high) begin
				r = fwd_model[n - 1];
				clip = 1'b1;
			end else begin
				r = grid_lookup(1'b1, n, v - cal_x_low, cal_x_scale, clip);
			end
		end else if (cal_enable) begin
			if (v < cal_y_low) begin
				r = cal_x_low;
				clip = 1'b1;
			end else if (v > cal_y_high) begin
				r = cal_x_high;
				clip = 1'b1;
			end else begin
				dy = cal_y_high - cal_y_low;
				dx = cal_x_high - cal_x_low;
				rising = (dy > 0 && dx > 0) || (dy < 0 && dx < 0);
				r = grid_lookup(1'b0, INV_POINTS, v - cal_y_low, cal_y_scale, clip);
				raw = r;
				// The order of the two limits depends on the slope direction.
				if (rising) begin
					if (r > cal_x_high) r = cal_x_high;
					if (r < cal_x_low) r = cal_x_low;
				end else begin
					if (r < cal_x_high) r = cal_x_high;
					if (r > cal_x_low) r = cal_x_low;
				end
				if (r != raw)
					clip = 1'b1;
			end
		end
		res.converted = r[VALUE_BITS-1:0];
		res.clamped = clip;
		return res;
	endfunction

	// Driver: presents the head request in bursts with random gaps between them.
	always @(negedge clk) begin
		if (gap_left > 0) begin
			start <= 1'b0;
			gap_left--;
		end else if (calib_requests.size() != 0) begin
			start <= 1'b1;
			kind <= calib_requests[0].kind;
			operand <= calib_requests[0].operand;
			entry_index <= calib_requests[0].entry_index;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Acceptance: table writes update the mirror, conversions queue a prediction.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			void'(calib_requests.pop_front());
			case (kind_t'(kind))
				KIND_WR_FWD: fwd_model[entry_index] = operand;
				KIND_WR_INV: inv_model[entry_index] = operand;
				default: pending_conversions.push_back(convert_point(kind_t'(kind), operand));
			endcase
		end
	end

	// Monitor: every done strobe is checked against the oldest prediction.
	always @(posedge clk) begin
		calib_result_t want;
		if (arst_n && done) begin
			if (pending_conversions.size() == 0) begin
				flag_fault($sformatf("unexpected result converted=%0d clamped=%0b",
					converted, clamped));
			end else begin
				want = pending_conversions.pop_front();
				if (converted !== want.converted)
					flag_fault($sformatf("converted: expected %0d, got %0d",
						want.converted, converted));
				if (clamped !== want.clamped)
					flag_fault($sformatf("clamped: expected %0b, got %0b",
						want.clamped, clamped));
			end
		end
	end

	// Watchdog on cycles without any accepted request, result or register write.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	// Writes one register and mirrors it once the write is taken.
	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] d);
		value_t v24;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		v24 = d[VALUE_BITS-1:0];
		case (r)
			REG_ENABLE:     cal_enable = d[0];
			REG_X_LOW:      cal_x_low = v24;
			REG_X_HIGH:     cal_x_high = v24;
			REG_X_SCALE:    cal_x_scale = d;
			REG_FWD_POINTS: cal_points = d[POINTS_BITS-1:0];
			REG_Y_LOW:      cal_y_low = v24;
			REG_Y_HIGH:     cal_y_high = v24;
			REG_Y_SCALE:    cal_y_scale = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Fills the bits above a register's width with random junk.
	function automatic logic [31:0] with_junk(input logic [31:0] v, input int bits);
		logic [31:0] mask;
		mask = (bits >= 32) ? 32'hFFFFFFFF : ((32'd1 << bits) - 1);
		return ($urandom & ~mask) | (v & mask);
	endfunction

	task automatic program_grid(input bit en, input longint xl, input longint xh,
			input logic [POINTS_BITS-1:0] pts, input logic [31:0] xs,
			input longint yl, input longint yh, input logic [31:0] ys);
		write_reg(REG_ENABLE, with_junk({31'd0, en}, 1));
		write_reg(REG_X_LOW, with_junk(xl[31:0], VALUE_BITS));
		write_reg(REG_X_HIGH, with_junk(xh[31:0], VALUE_BITS));
		write_reg(REG_X_SCALE, xs);
		write_reg(REG_FWD_POINTS, with_junk({21'd0, pts}, POINTS_BITS));
		write_reg(REG_Y_LOW, with_junk(yl[31:0], VALUE_BITS));
		write_reg(REG_Y_HIGH, with_junk(yh[31:0], VALUE_BITS));
		write_reg(REG_Y_SCALE, ys);
	endtask

	// Waits until every request is taken and every result has arrived.
	task automatic drain();
		while (calib_requests.size() != 0 || pending_conversions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_request(input kind_t k, input longint v, input int idx);
		calib_req_t req;
		req.kind = k;
		req.operand = v[VALUE_BITS-1:0];
		req.entry_index = idx[ENTRY_BITS-1:0];
		calib_requests.push_back(req);
	endtask

	// Operand near a grid range, at its edges, or anywhere in the value range.
	function automatic longint near_range(input longint a, input longint b);
		longint lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case ($urandom_range(0, 9))
			0, 1: return longint'(value_t'($urandom));
			2: begin
				case ($urandom_range(0, 5))
					0: return lo;
					1: return hi;
					2: return (lo > VALUE_MIN) ? lo - 1 : lo;
					3: return (hi < VALUE_MAX) ? hi + 1 : hi;
					4: return VALUE_MIN;
					default: return VALUE_MAX;
				endcase
			end
			default: begin
				lo = (lo - 2 < VALUE_MIN) ? VALUE_MIN : lo - 2;
				hi = (hi + 2 > VALUE_MAX) ? VALUE_MAX : hi + 2;
				return lo + longint'($urandom_range(0, 32'(hi - lo)));
			end
		endcase
	endfunction

	task automatic queue_random_requests(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: queue_request(KIND_WR_FWD, near_range(VALUE_MIN, VALUE_MAX),
					$urandom_range(0, FWD_DEPTH - 1));
				1: queue_request(KIND_WR_INV, near_range(cal_x_low, cal_x_high),
					$urandom_range(0, INV_POINTS - 1));
				2, 3, 4: queue_request(KIND_FWD, near_range(cal_x_low, cal_x_high),
					$urandom_range(0, FWD_DEPTH - 1));
				default: queue_request(KIND_INV, near_range(cal_y_low, cal_y_high),
					$urandom_range(0, INV_POINTS - 1));
			endcase
		end
	endtask

	task automatic random_range(output longint lo, output longint hi);
		longint span, base;
		case ($urandom_range(0, 3))
			0: span = $urandom_range(0, 64);
			1: span = $urandom_range(1, 4096);
			2: span = $urandom_range(1, 1 << 20);
			default: span = $urandom_range(1, 16777215);
		endcase
		base = longint'($urandom_range(0, 32'(16777215 - span))) + VALUE_MIN;
		lo = base;
		hi = base + span;
		// Some grids run downward.
		if ($urandom_range(0, 4) == 0) begin
			lo = base + span;
			hi = base;
		end
	endtask

	// Scale that fits the grid, sometimes nudged past it or fully random.
	function automatic logic [31:0] fit_scale(input longint steps, input longint lo,
			input longint hi);
		longint s;
		if (hi > lo)
			s = (steps << FRAC_BITS) / (hi - lo);
		else
			s = $urandom_range(0, 1 << 20);
		case ($urandom_range(0, 9))
			7: s = s + $urandom_range(1, 3);
			8: s = $urandom;
			9: s = 64'hFFFFFFFF;
			default: ;
		endcase
		if (s > 64'hFFFFFFFF)
			s = 64'hFFFFFFFF;
		return s[31:0];
	endfunction

	task automatic random_grid();
		longint xl, xh, yl, yh, n;
		logic [POINTS_BITS-1:0] pts;
		random_range(xl, xh);
		random_range(yl, yh);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: pts = 11'd0;
					1: pts = 11'd1;
					2: pts = 11'd1025;
					3: pts = 11'd2047;
					default: pts = 11'd1024;
				endcase
			end
			7, 8: pts = POINTS_BITS'($urandom_range(2, FWD_DEPTH));
			default: pts = POINTS_BITS'($urandom_range(2, 64));
		endcase
		n = pts;
		if (n < 2) n = 2;
		if (n > FWD_DEPTH) n = FWD_DEPTH;
		program_grid($urandom_range(0, 9) != 0, xl, xh, pts, fit_scale(n - 1, xl, xh),
			yl, yh, fit_scale(INV_POINTS - 1, yl, yh));
	endtask

	// Stimulus sequence.
	initial begin
		cal_enable = 1'b0;
		cal_x_low = 0;
		cal_x_high = 0;
		cal_y_low = 0;
		cal_y_high = 0;
		cal_x_scale = 0;
		cal_y_scale = 0;
		cal_points = 2;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load both tables completely so that no conversion reads an unwritten entry.
		for (int i = 0; i < FWD_DEPTH; i++)
			queue_request(KIND_WR_FWD, near_range(VALUE_MIN, VALUE_MAX), i);
		for (int i = 0; i < INV_POINTS; i++)
			queue_request(KIND_WR_INV, i * 16 + $urandom_range(0, 40) - 20, i);
		// Conversions while disabled return zero.
		queue_random_requests(PHASE_REQUESTS / 2);
		drain();

		// Enable alone, so the other registers keep their reset values.
		write_reg(REG_ENABLE, with_junk(32'd1, 1));
		queue_random_requests(PHASE_REQUESTS / 2);
		drain();

		// Directed requests on an exact grid: sixteen x units per step.
		program_grid(1'b1, 0, 16368, 11'd1024, 32'd4096, -8184, 8184, 32'd4096);
		queue_request(KIND_WR_FWD, 10, 0);
		queue_request(KIND_WR_FWD, 13, 1);
		queue_request(KIND_WR_FWD, 10, 2);
		queue_request(KIND_FWD, 0, 0);
		queue_request(KIND_FWD, 8, 0);        // tie, rising segment
		queue_request(KIND_FWD, 24, 0);       // tie, falling segment
		queue_request(KIND_FWD, -1, 0);
		queue_request(KIND_FWD, 16368, 0);    // exact upper grid end
		queue_request(KIND_FWD, 16369, 0);
		queue_request(KIND_FWD, VALUE_MIN, 0);
		queue_request(KIND_FWD, VALUE_MAX, 0);
		queue_request(KIND_FWD, 5, 0);
		queue_request(KIND_INV, -8184, 0);
		queue_request(KIND_INV, 8184, 0);
		queue_request(KIND_INV, -8185, 0);
		queue_request(KIND_INV, 8185, 0);
		queue_request(KIND_INV, VALUE_MIN, 0);
		queue_request(KIND_INV, VALUE_MAX, 0);
		queue_request(KIND_INV, 3, 0);
		queue_request(KIND_WR_INV, VALUE_MAX, INV_POINTS - 1);
		queue_request(KIND_INV, 8184, 0);     // capped at x_high
		queue_request(KIND_WR_INV, VALUE_MIN, 0);
		queue_request(KIND_INV, -8184, 0);    // raised to x_low
		queue_request(KIND_WR_FWD, VALUE_MIN, FWD_DEPTH - 1);
		queue_request(KIND_FWD, 16368, 0);
		drain();
		queue_random_requests(PHASE_REQUESTS);
		drain();

		// Full value range on both grids.
		program_grid(1'b1, VALUE_MIN, VALUE_MAX, 11'd1024, 32'd3, VALUE_MIN, VALUE_MAX, 32'd4);
		queue_random_requests(PHASE_REQUESTS);
		drain();

		// Falling x grid, so inverse results are limited the other way round.
		program_grid(1'b1, 16368, 0, 11'd1024, 32'd4096, -8184, 8184, 32'd4096);
		queue_random_requests(PHASE_REQUESTS);
		drain();

		// Point count below range, maximum x scale, empty inverse range.
		program_grid(1'b1, VALUE_MIN, VALUE_MAX, 11'd0, 32'hFFFFFFFF,
			VALUE_MAX, VALUE_MIN, 32'd0);
		queue_random_requests(PHASE_REQUESTS);
		drain();

		// Disabled block with a point count above range.
		program_grid(1'b0, -100, 100, 11'd2047, 32'd0, -100, 100, 32'd0);
		queue_random_requests(PHASE_REQUESTS);
		drain();

		// Two forward points and a one-unit inverse range that ends on the last entry.
		program_grid(1'b1, -1, 1, 11'd2, 32'd32768, 0, 1, 32'd67043328);
		queue_random_requests(PHASE_REQUESTS);
		drain();

		// Random grids.
		for (int phase = 0; phase < 6; phase++) begin
			random_grid();
			queue_random_requests(PHASE_REQUESTS);
			drain();
		end

		if (pending_conversions.size() != 0)
			flag_fault($sformatf("%0d results never arrived", pending_conversions.size()));
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
